// ===== src/levaut_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// levaut_pkg
// Shared widths, codes and controller/datapath types for the Levenshtein
// automaton step core.
// ----------------------------------------------------------------------------
package levaut_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int SYMBOL_BITS_DEF = 16;

	localparam int CMD_BITS       = 2;
	localparam int POS_BITS       = 4;
	localparam int SYM_PORT_BITS  = 16;
	localparam int DIST_BITS      = 4;
	localparam int MAXD_BITS      = 3;
	localparam int PLEN_BITS      = 5;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 5;

	// stored cost of a dead position
	localparam logic [DIST_BITS-1:0] ROW_DEAD = 4'hF;

	localparam logic [MAXD_BITS-1:0] MAXD_RESET = 3'd1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_STEP  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_MAX_DISTANCE   = 1'b0,
		CFG_PATTERN_LENGTH = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // word accepted: latch it, write pattern on load
		logic sweep;     // one row position is processed this cycle
		logic load_out;  // move sweep status into the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register can take a word this cycle
	} dp_status_t;

endpackage
`default_nettype wire

// ===== src/levaut_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// levaut_in_if / levaut_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface levaut_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [levaut_pkg::CMD_BITS-1:0]        cmd;
	logic [levaut_pkg::POS_BITS-1:0]        position;
	logic [levaut_pkg::SYM_PORT_BITS-1:0]   symbol;

	modport source (output valid, cmd, position, symbol, input ready);
	modport sink   (input valid, cmd, position, symbol, output ready);
endinterface

interface levaut_out_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   is_match;
	logic                                   can_match;
	logic [levaut_pkg::DIST_BITS-1:0]       distance;

	modport source (output valid, is_match, can_match, distance, input ready);
	modport sink   (input valid, is_match, can_match, distance, output ready);
endinterface
`default_nettype wire

// ===== src/levaut_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// levaut_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module levaut_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/levaut_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// levaut_ctrl
// Sequencer: accepts a word, sweeps the cost row one position per cycle,
// then hands the status to the output register.
// ----------------------------------------------------------------------------
module levaut_ctrl #(
	parameter int PATTERN_MAX = levaut_pkg::PATTERN_MAX_DEF,
	localparam int KW = $clog2(PATTERN_MAX + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire levaut_pkg::dp_status_t status,
	output levaut_pkg::ctrl_cmd_t       cmd,
	output logic [KW-1:0]               k
);

	localparam logic [KW-1:0] K_LAST = KW'(PATTERN_MAX);

	levaut_pkg::state_t state_q, state_n;
	logic [KW-1:0]      k_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			levaut_pkg::ST_IDLE: begin
				if (item_valid) state_n = levaut_pkg::ST_SWEEP;
			end
			levaut_pkg::ST_SWEEP: begin
				if (k_q == K_LAST) state_n = levaut_pkg::ST_FINISH;
			end
			levaut_pkg::ST_FINISH: begin
				if (status.out_free) state_n = levaut_pkg::ST_IDLE;
			end
			default: state_n = levaut_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready   = 1'b0;
		cmd.capture  = 1'b0;
		cmd.sweep    = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			levaut_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			levaut_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
			end
			levaut_pkg::ST_FINISH: begin
				cmd.load_out = status.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= levaut_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == levaut_pkg::ST_SWEEP && k_q != K_LAST) begin
				k_q <= k_q + KW'(1);
			end else begin
				k_q <= '0;
			end
		end
	end

	assign k = k_q;

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == levaut_pkg::ST_SWEEP && k_q == K_LAST) |=> state_q == levaut_pkg::ST_FINISH)
		else $error("sweep did not end after the last row position");

	a_out_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == levaut_pkg::ST_IDLE)
		else $error("controller not idle after result hand-off");

	a_k_parked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != levaut_pkg::ST_SWEEP |-> k_q == '0)
		else $error("position counter not parked outside a sweep");

endmodule
`default_nettype wire

// ===== src/levaut_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// levaut_dp
// Datapath: config registers, pattern RAM, circular cost row and the
// per-position Levenshtein update, live tracking and output register.
// ----------------------------------------------------------------------------
module levaut_dp #(
	parameter int PATTERN_MAX = levaut_pkg::PATTERN_MAX_DEF,
	parameter int SYMBOL_BITS = levaut_pkg::SYMBOL_BITS_DEF,
	localparam int KW = $clog2(PATTERN_MAX + 1)
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire levaut_pkg::ctrl_cmd_t                   cmd,
	input  wire logic [KW-1:0]                           k,
	input  wire logic [levaut_pkg::CMD_BITS-1:0]         item_cmd,
	input  wire logic [levaut_pkg::POS_BITS-1:0]         item_position,
	input  wire logic [levaut_pkg::SYM_PORT_BITS-1:0]    item_symbol,
	input  wire logic                                    cfg_wen,
	input  wire logic [levaut_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [levaut_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	levaut_out_if.source                                 result,
	output levaut_pkg::dp_status_t                       status
);

	localparam int N  = PATTERN_MAX + 1;
	localparam int PA = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int DB = levaut_pkg::DIST_BITS;
	localparam int XW = (KW > DB) ? KW : DB;
	localparam int CW = (KW > levaut_pkg::PLEN_BITS) ? KW : levaut_pkg::PLEN_BITS;

	// config
	logic [levaut_pkg::MAXD_BITS-1:0] max_distance_q;
	logic [levaut_pkg::PLEN_BITS-1:0] pattern_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q   <= levaut_pkg::MAXD_RESET;
			pattern_length_q <= '0;
		end else if (cfg_wen) begin
			unique case (levaut_pkg::cfg_index_t'(cfg_index))
				levaut_pkg::CFG_MAX_DISTANCE:
					max_distance_q <= cfg_data[levaut_pkg::MAXD_BITS-1:0];
				levaut_pkg::CFG_PATTERN_LENGTH:
					pattern_length_q <= cfg_data[levaut_pkg::PLEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// effective length, clipped to PATTERN_MAX
	logic [CW-1:0] plen_w;
	logic [KW-1:0] len;
	assign plen_w = CW'(pattern_length_q);
	assign len    = (plen_w > CW'(PATTERN_MAX)) ? KW'(PATTERN_MAX) : KW'(plen_w);

	// latched word
	logic [levaut_pkg::CMD_BITS-1:0] cmd_q;
	logic [SYMBOL_BITS-1:0]          sym_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= item_cmd;
			sym_q <= SYMBOL_BITS'(item_symbol);
		end
	end

	// pattern store; read address runs one position ahead of its use
	logic                   ram_we;
	logic [PA-1:0]          ram_raddr;
	logic [SYMBOL_BITS-1:0] ram_rdata;

	assign ram_we = cmd.capture && (item_cmd == levaut_pkg::CMD_LOAD)
		&& (8'(item_position) < 8'(PATTERN_MAX));
	assign ram_raddr = (k < KW'(PATTERN_MAX)) ? PA'(k) : '0;

	levaut_ram #(
		.WIDTH (SYMBOL_BITS),
		.DEPTH (PATTERN_MAX)
	) u_pattern (
		.clk   (clk),
		.we    (ram_we),
		.waddr (PA'(item_position)),
		.wdata (SYMBOL_BITS'(item_symbol)),
		.re    (cmd.sweep),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// cost row as a rotating shift line: head is position k during the sweep
	logic [DB-1:0] row_q [N];
	logic [DB-1:0] prev_cur_q, nxt_prev_q;
	logic          any_q, match_q;
	logic [DB-1:0] dist_q;

	logic [DB-1:0] m4, dead, head, cur, a_sub, b_ins, c_del, cand, nv, w;
	logic          k_le_len, k_eq_len, live, neq;

	assign m4       = DB'(max_distance_q);
	assign dead     = m4 + DB'(1);
	assign head     = row_q[0];
	assign cur      = (head > dead) ? dead : head;
	assign k_le_len = (k <= len);
	assign k_eq_len = (k == len);
	assign neq      = (ram_rdata != sym_q);

	always_comb begin
		a_sub = prev_cur_q + (neq ? DB'(1) : DB'(0));
		b_ins = nxt_prev_q + DB'(1);
		c_del = cur + DB'(1);
		cand  = (c_del < dead) ? c_del : dead;
		if (k != '0) begin
			if (a_sub < cand) cand = a_sub;
			if (b_ins < cand) cand = b_ins;
		end
	end

	always_comb begin
		nv = dead;
		w  = head;
		unique case (cmd_q)
			levaut_pkg::CMD_STEP: begin
				nv = k_le_len ? cand : dead;
				w  = (k_le_len && nv <= m4) ? nv : levaut_pkg::ROW_DEAD;
			end
			levaut_pkg::CMD_START: begin
				w = (k_le_len && XW'(k) <= XW'(max_distance_q)) ? DB'(k)
					: levaut_pkg::ROW_DEAD;
			end
			default: w = head;  // load and no-op keep the row
		endcase
	end

	assign live = k_le_len && (w <= m4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < N; j++) row_q[j] <= levaut_pkg::ROW_DEAD;
		end else if (cmd.sweep) begin
			for (int j = 0; j < N - 1; j++) row_q[j] <= row_q[j+1];
			row_q[N-1] <= w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			prev_cur_q <= cur;
			nxt_prev_q <= nv;
			if (k == '0) begin
				any_q   <= live;
				dist_q  <= live ? w : dead;
				match_q <= k_eq_len && live;
			end else begin
				if (live) begin
					any_q  <= 1'b1;
					dist_q <= w;
				end
				if (k_eq_len) match_q <= live;
			end
		end
	end

	// output register
	logic          out_valid_q;
	logic          is_match_q, can_match_q;
	logic [DB-1:0] distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			is_match_q  <= match_q;
			can_match_q <= any_q;
			distance_q  <= dist_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.is_match  = is_match_q;
	assign result.can_match = can_match_q;
	assign result.distance  = distance_q;
	assign status.out_free  = !out_valid_q || result.ready;

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result word not presented after hand-off");

	a_match_is_live: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_match_q) |-> can_match_q)
		else $error("match reported with no live position");

endmodule
`default_nettype wire

// ===== src/levenshtein_automaton_step_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// levenshtein_automaton_step_core
// Levenshtein automaton for one stored pattern: load / start / step words,
// one status word (match, can-match, distance) back for every command word.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   item     in   valid/ready      cmd[1:0] position[3:0] symbol[15:0]
//   result   out  valid/ready      is_match can_match distance[3:0]
//   cfg      in   cfg_wen          cfg_index[0] cfg_data[4:0]
//
// Sequence: each word is accepted, then the cost row is swept serially one
//   position at a time, then the status is handed to the output register.
//   The serial sweep over the rotating row and the single pattern RAM read
//   port set how long a word takes; a new word is taken only when idle.
// Reset: cost row all dead, max_distance = 1, pattern_length = 0, no result
//   pending. Pattern RAM is not cleared; unwritten entries read as garbage.
// Stalls: a finished result waits in the output register while the next word
//   is accepted; the core only holds at the end of a sweep if that register
//   is still full.
// ----------------------------------------------------------------------------
module levenshtein_automaton_step_core #(
	parameter int PATTERN_MAX = levaut_pkg::PATTERN_MAX_DEF,
	parameter int SYMBOL_BITS = levaut_pkg::SYMBOL_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	levaut_in_if.sink                                  item,
	levaut_out_if.source                               result,
	input  wire logic                                  cfg_wen,
	input  wire logic [levaut_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [levaut_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int KW = $clog2(PATTERN_MAX + 1);

	levaut_pkg::ctrl_cmd_t  ctl_cmd;
	levaut_pkg::dp_status_t dp_status;
	logic [KW-1:0]          row_pos;   // row position under the sweep
	logic                   ready_w;

	levaut_ctrl #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (ready_w),
		.status     (dp_status),
		.cmd        (ctl_cmd),
		.k          (row_pos)
	);

	assign item.ready = ready_w;

	levaut_dp #(
		.PATTERN_MAX (PATTERN_MAX),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.k             (row_pos),
		.item_cmd      (item.cmd),
		.item_position (item.position),
		.item_symbol   (item.symbol),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result        (result),
		.status        (dp_status)
	);

endmodule
`default_nettype wire
